>>> sv/tpq_pkg.sv
// ----------------------------------------------------------------------------
// tpq_pkg
// Shared codes and types for the two-level priority transmit queue.
// ----------------------------------------------------------------------------
package tpq_pkg;

  localparam int OP_BITS     = 2;
  localparam int STATUS_BITS = 2;

  localparam logic [OP_BITS-1:0] OP_PUSH   = 2'd0;
  localparam logic [OP_BITS-1:0] OP_POP    = 2'd1;
  localparam logic [OP_BITS-1:0] OP_CANCEL = 2'd2;

  localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd2;

  typedef enum logic [0:0] {
    S_IDLE,
    S_CANCEL
  } tpq_state_t;

  // per-level command to every cell of a chain
  typedef struct packed {
    logic shift;  // advance every entry one place towards the head
    logic ins;    // write the insert data into the first free place
  } tpq_cell_ctl_t;

endpackage

>>> sv/tpq_if.sv
// ----------------------------------------------------------------------------
// tpq_in_if / tpq_out_if
// Valid/ready channels for queue requests and queue results.
// ----------------------------------------------------------------------------
interface tpq_in_if import tpq_pkg::*; #(
  parameter int TAG_BITS     = 8,
  parameter int PAYLOAD_BITS = 32
);
  logic                    valid;
  logic                    ready;
  logic [OP_BITS-1:0]      op;
  logic                    level;
  logic                    max_level;
  logic [TAG_BITS-1:0]     tag;
  logic [PAYLOAD_BITS-1:0] payload;

  modport source (output valid, op, level, max_level, tag, payload, input ready);
  modport sink   (input valid, op, level, max_level, tag, payload, output ready);
endinterface

interface tpq_out_if import tpq_pkg::*; #(
  parameter int TAG_BITS     = 8,
  parameter int PAYLOAD_BITS = 32,
  parameter int COUNT_BITS   = 6
);
  logic                    valid;
  logic                    ready;
  logic [STATUS_BITS-1:0]  status;
  logic [TAG_BITS-1:0]     out_tag;
  logic [PAYLOAD_BITS-1:0] out_payload;
  logic [COUNT_BITS-1:0]   removed_count;
  logic                    all_empty;
  logic                    tx_notify;

  modport source (output valid, status, out_tag, out_payload, removed_count,
                  all_empty, tx_notify, input ready);
  modport sink   (input valid, status, out_tag, out_payload, removed_count,
                  all_empty, tx_notify, output ready);
endinterface

>>> sv/tpq_cell.sv
// ----------------------------------------------------------------------------
// tpq_cell
// One place of a queue chain: holds a valid flag, a tag and a payload.
// ----------------------------------------------------------------------------
module tpq_cell import tpq_pkg::*; #(
  parameter int TAG_BITS     = 8,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  tpq_cell_ctl_t           ctl,
  input  logic [TAG_BITS-1:0]     ins_tag,
  input  logic [PAYLOAD_BITS-1:0] ins_payload,
  input  logic                    prev_valid,
  input  logic                    next_valid,
  input  logic [TAG_BITS-1:0]     next_tag,
  input  logic [PAYLOAD_BITS-1:0] next_payload,
  output logic                    valid,
  output logic [TAG_BITS-1:0]     tag,
  output logic [PAYLOAD_BITS-1:0] payload
);

  logic                    valid_r, valid_nxt;
  logic [TAG_BITS-1:0]     tag_r, tag_nxt;
  logic [PAYLOAD_BITS-1:0] payload_r, payload_nxt;
  logic                    ins_here;

  always_comb begin
    // first free place after this cycle's shift, if any
    if (ctl.shift) begin
      ins_here = ctl.ins && valid_r && !next_valid;
    end else begin
      ins_here = ctl.ins && !valid_r && prev_valid;
    end
    valid_nxt   = ctl.shift ? next_valid : valid_r;
    tag_nxt     = ctl.shift ? next_tag : tag_r;
    payload_nxt = ctl.shift ? next_payload : payload_r;
    if (ins_here) begin
      valid_nxt   = 1'b1;
      tag_nxt     = ins_tag;
      payload_nxt = ins_payload;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r     <= tag_nxt;
    payload_r <= payload_nxt;
  end

  assign valid   = valid_r;
  assign tag     = tag_r;
  assign payload = payload_r;

endmodule

>>> sv/tpq_chain.sv
// ----------------------------------------------------------------------------
// tpq_chain
// Row of queue cells for one level, oldest entry in the head cell.
// ----------------------------------------------------------------------------
module tpq_chain import tpq_pkg::*; #(
  parameter int LEVEL_DEPTH  = 16,
  parameter int TAG_BITS     = 8,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  tpq_cell_ctl_t           ctl,
  input  logic [TAG_BITS-1:0]     ins_tag,
  input  logic [PAYLOAD_BITS-1:0] ins_payload,
  output logic [TAG_BITS-1:0]     head_tag,
  output logic [PAYLOAD_BITS-1:0] head_payload
);

  // one extra place on each side: a full slot before the head, empty after the tail
  logic                    v   [LEVEL_DEPTH+2];
  logic [TAG_BITS-1:0]     t   [LEVEL_DEPTH+2];
  logic [PAYLOAD_BITS-1:0] p   [LEVEL_DEPTH+2];

  assign v[0]             = 1'b1;
  assign t[0]             = '0;
  assign p[0]             = '0;
  assign v[LEVEL_DEPTH+1] = 1'b0;
  assign t[LEVEL_DEPTH+1] = '0;
  assign p[LEVEL_DEPTH+1] = '0;

  for (genvar i = 1; i <= LEVEL_DEPTH; i++) begin : g_cell
    tpq_cell #(
      .TAG_BITS     (TAG_BITS),
      .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctl          (ctl),
      .ins_tag      (ins_tag),
      .ins_payload  (ins_payload),
      .prev_valid   (v[i-1]),
      .next_valid   (v[i+1]),
      .next_tag     (t[i+1]),
      .next_payload (p[i+1]),
      .valid        (v[i]),
      .tag          (t[i]),
      .payload      (p[i])
    );
  end

  assign head_tag     = t[1];
  assign head_payload = p[1];

endmodule

>>> sv/two_level_priority_tx_queue.sv
// ----------------------------------------------------------------------------
// two_level_priority_tx_queue
// Strict-priority transmit queue with two levels, built as cell chains.
// ----------------------------------------------------------------------------
// Two FIFO frame queues of LEVEL_DEPTH entries each; level 0 is the urgent
// level. Each request gives exactly one result transaction. A push or a pop
// has its result in the output register in the cycle after it is taken; a
// new push or pop may follow in every cycle while the output is taken. A
// cancel runs every entry of both levels once past the head of its chain,
// in parallel for both levels, re-queueing those whose tag does not match:
// it keeps the block busy until the longer of the two chains is swept.
// There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module two_level_priority_tx_queue import tpq_pkg::*; #(
  parameter int LEVEL_DEPTH  = 16,
  parameter int TAG_BITS     = 8,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  tpq_in_if.sink    in_ch,
  tpq_out_if.source out_ch
);

  localparam int CW = $clog2(LEVEL_DEPTH + 1);      // one level's count
  localparam int RW = $clog2(2 * LEVEL_DEPTH + 1);  // frames removed by a cancel

  tpq_state_t state_r, state_nxt;

  logic [CW-1:0]       count_r [2];
  logic [CW-1:0]       count_nxt [2];
  logic [CW-1:0]       snap_r [2];
  logic [CW-1:0]       snap_nxt [2];
  logic [CW-1:0]       iter_r, iter_nxt;
  logic [CW-1:0]       limit_r, limit_nxt;
  logic [TAG_BITS-1:0] ctag_r, ctag_nxt;
  logic [RW-1:0]       racc_r, racc_nxt;

  // output register
  logic                    ovalid_r, ovalid_nxt;
  logic [STATUS_BITS-1:0]  ostatus_r, ostatus_nxt;
  logic [TAG_BITS-1:0]     otag_r, otag_nxt;
  logic [PAYLOAD_BITS-1:0] opay_r, opay_nxt;
  logic [RW-1:0]           orem_r, orem_nxt;
  logic                    oempty_r, oempty_nxt;
  logic                    onotify_r, onotify_nxt;

  tpq_cell_ctl_t           ctl [2];
  logic [TAG_BITS-1:0]     ins_tag [2];
  logic [PAYLOAD_BITS-1:0] ins_pay [2];
  logic [TAG_BITS-1:0]     head_tag [2];
  logic [PAYLOAD_BITS-1:0] head_pay [2];

  logic accept;
  logic load;

  // take a request only when idle and the output register is free by the next edge
  assign in_ch.ready = (state_r == S_IDLE) && (!ovalid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    state_nxt    = state_r;
    count_nxt[0] = count_r[0];
    count_nxt[1] = count_r[1];
    snap_nxt[0]  = snap_r[0];
    snap_nxt[1]  = snap_r[1];
    iter_nxt     = iter_r;
    limit_nxt    = limit_r;
    ctag_nxt     = ctag_r;
    racc_nxt     = racc_r;
    ctl[0]       = '0;
    ctl[1]       = '0;
    load         = 1'b0;
    ostatus_nxt  = ST_OK;
    otag_nxt     = '0;
    opay_nxt     = '0;
    orem_nxt     = '0;
    onotify_nxt  = 1'b0;
    for (int l = 0; l < 2; l++) begin
      ins_tag[l] = (state_r == S_CANCEL) ? head_tag[l] : in_ch.tag;
      ins_pay[l] = (state_r == S_CANCEL) ? head_pay[l] : in_ch.payload;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          load = 1'b1;
          unique case (in_ch.op)
            OP_PUSH: begin
              if (count_r[in_ch.level] == CW'(LEVEL_DEPTH)) begin
                ostatus_nxt = ST_FULL;
              end else begin
                ctl[in_ch.level].ins = 1'b1;
                count_nxt[in_ch.level] = count_r[in_ch.level] + CW'(1);
                onotify_nxt = 1'b1;
              end
            end
            OP_POP: begin
              priority if (count_r[0] != '0) begin
                ctl[0].shift = 1'b1;
                count_nxt[0] = count_r[0] - CW'(1);
                otag_nxt     = head_tag[0];
                opay_nxt     = head_pay[0];
              end else if (in_ch.max_level && count_r[1] != '0) begin
                ctl[1].shift = 1'b1;
                count_nxt[1] = count_r[1] - CW'(1);
                otag_nxt     = head_tag[1];
                opay_nxt     = head_pay[1];
              end else begin
                ostatus_nxt = ST_EMPTY;
              end
            end
            OP_CANCEL: begin
              // hold the result until both chains have been swept
              load        = 1'b0;
              state_nxt   = S_CANCEL;
              snap_nxt[0] = count_r[0];
              snap_nxt[1] = count_r[1];
              iter_nxt    = '0;
              limit_nxt   = (count_r[0] > count_r[1]) ? count_r[0] : count_r[1];
              ctag_nxt    = in_ch.tag;
              racc_nxt    = '0;
            end
            default: begin
              // unused op: no change, plain result
            end
          endcase
        end
      end
      S_CANCEL: begin
        if (iter_r == limit_r) begin
          load      = 1'b1;
          orem_nxt  = racc_r;
          state_nxt = S_IDLE;
        end else begin
          iter_nxt = iter_r + CW'(1);
          for (int l = 0; l < 2; l++) begin
            // pop the head, requeue it at the tail unless the tag matches
            if (iter_r < snap_r[l]) begin
              ctl[l].shift = 1'b1;
              if (head_tag[l] != ctag_r) begin
                ctl[l].ins = 1'b1;
              end else begin
                count_nxt[l] = count_nxt[l] - CW'(1);
                racc_nxt     = racc_nxt + RW'(1);
              end
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    oempty_nxt = (count_nxt[0] == '0) && (count_nxt[1] == '0);

    if (load) begin
      ovalid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      ovalid_nxt = 1'b0;
    end else begin
      ovalid_nxt = ovalid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      count_r[0] <= '0;
      count_r[1] <= '0;
      ovalid_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r[0] <= count_nxt[0];
      count_r[1] <= count_nxt[1];
      ovalid_r   <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    snap_r[0] <= snap_nxt[0];
    snap_r[1] <= snap_nxt[1];
    iter_r    <= iter_nxt;
    limit_r   <= limit_nxt;
    ctag_r    <= ctag_nxt;
    racc_r    <= racc_nxt;
    if (load) begin
      ostatus_r <= ostatus_nxt;
      otag_r    <= otag_nxt;
      opay_r    <= opay_nxt;
      orem_r    <= orem_nxt;
      oempty_r  <= oempty_nxt;
      onotify_r <= onotify_nxt;
    end
  end

  // level 0: urgent chain
  tpq_chain #(
    .LEVEL_DEPTH  (LEVEL_DEPTH),
    .TAG_BITS     (TAG_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_chain0 (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl[0]),
    .ins_tag      (ins_tag[0]),
    .ins_payload  (ins_pay[0]),
    .head_tag     (head_tag[0]),
    .head_payload (head_pay[0])
  );

  // level 1: normal chain
  tpq_chain #(
    .LEVEL_DEPTH  (LEVEL_DEPTH),
    .TAG_BITS     (TAG_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_chain1 (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl[1]),
    .ins_tag      (ins_tag[1]),
    .ins_payload  (ins_pay[1]),
    .head_tag     (head_tag[1]),
    .head_payload (head_pay[1])
  );

  assign out_ch.valid         = ovalid_r;
  assign out_ch.status        = ostatus_r;
  assign out_ch.out_tag       = otag_r;
  assign out_ch.out_payload   = opay_r;
  assign out_ch.removed_count = orem_r;
  assign out_ch.all_empty     = oempty_r;
  assign out_ch.tx_notify     = onotify_r;

endmodule
